@@ hdl/tcce_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package tcce_pkg;

	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CHAR_W = 8;
	localparam int CELL_W = 16;

	localparam logic [CELL_W-1:0] BLANK_CELL   = 16'hF000;
	localparam logic [7:0]        INSERT_COLOR = 8'hF0;
	localparam logic [CHAR_W-1:0] NEWLINE      = 8'd10;

	typedef enum logic [2:0] {
		CMD_WRITE = 3'd0,
		CMD_PRINT = 3'd1,
		CMD_INSERT = 3'd2,
		CMD_BKSP  = 3'd3,
		CMD_RIGHT = 3'd4,
		CMD_LEFT  = 3'd5,
		CMD_CLEAR = 3'd6,
		CMD_SETCUR = 3'd7
	} cmd_t;

	typedef enum logic {
		REG_LIMIT_ROW = 1'b0,
		REG_LIMIT_COL = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_FILL,
		ST_IDLE,
		ST_EXEC,
		ST_COPY,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_RIGHT,
		ST_LEFT,
		ST_PUT,
		ST_NEWLINE,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		JOB_INIT,
		JOB_CLEAR,
		JOB_SCROLL,
		JOB_SHIFT,
		JOB_BKSP,
		JOB_ROWSCAN
	} job_t;

endpackage
`default_nettype wire

@@ hdl/tcce_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tcce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ hdl/text_console_cell_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Text console cell engine: one command word in, one cursor word out, one command at a time.
// Write cell and set cursor need no walk over cells; a print writes its cell and steps the cursor;
// a left move that climbs scans the row above for its first empty cell; backspace mid-row shifts the
// rest of the row left; insert moves its run up; clear blanks every cell; a scroll moves rows up.
// Throughput: the next command waits for the last result word; copies move one cell per cycle.
// Reset: cursor and limits go to zero, then all ROWS*COLUMNS cells are zeroed, in_ready low.
module text_console_cell_engine import tcce_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [2:0]        command,
	input  wire logic [ROW_W-1:0]  row,
	input  wire logic [COL_W-1:0]  col,
	input  wire logic [CHAR_W-1:0] char_code,
	input  wire logic [3:0]        fg,
	input  wire logic [3:0]        bg,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [ROW_W-1:0]       cursor_row,
	output logic [COL_W-1:0]       cursor_col,
	output logic                   success,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [COL_W-1:0]  cfg_data
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
	localparam logic [AW-1:0]    LAST_CELL = AW'(CELLS - 1);
	localparam logic [AW-1:0]    ROW_SPAN  = AW'(COLUMNS);

	state_t state_q, state_d;
	job_t   job_q;

	// latched command word
	cmd_t              cmd_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [CHAR_W-1:0] ch_q;
	logic [7:0]        color_q;

	logic [ROW_W-1:0] cur_row_q;
	logic [COL_W-1:0] cur_col_q;
	logic [ROW_W-1:0] lim_row_q;
	logic [COL_W-1:0] lim_col_q;
	logic             ok_q;

	// walk pointers: a_q is the source / scan / fill pointer, b_q the copy destination
	logic [AW-1:0] a_q, b_q, cnt_q;
	logic          up_q;
	logic          pend_s1;
	logic [AW-1:0] wdst_s1;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [CELL_W-1:0] ram_wdata, ram_rdata;

	logic [AW-1:0] pos;
	logic          at_prompt;
	logic          rd_full;
	logic          out_free;

	assign pos       = AW'(cur_row_q) * ROW_SPAN + AW'(cur_col_q);
	assign at_prompt = (cur_row_q == lim_row_q) &&
		({1'b0, cur_col_q} == ({1'b0, lim_col_q} + 8'd1));
	assign rd_full   = (ram_rdata[CHAR_W-1:0] != '0);
	assign out_free  = !out_valid || out_ready;
	assign in_ready  = (state_q == ST_IDLE);

	tcce_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_FILL: begin
				if (a_q == LAST_CELL) begin
					state_d = (job_q == JOB_INIT) ? ST_IDLE : ST_DONE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (cmd_q)
					CMD_WRITE, CMD_SETCUR: state_d = ST_DONE;
					CMD_PRINT: begin
						if (ch_q == NEWLINE) state_d = ST_NEWLINE;
						else if (ch_q == '0) state_d = ST_DONE;
						else state_d = ST_PUT;
					end
					CMD_INSERT: state_d = (ch_q == NEWLINE) ? ST_NEWLINE : ST_SCAN_RD;
					CMD_BKSP: begin
						if (!at_prompt && cur_col_q != '0 && cur_col_q != LAST_COL) begin
							state_d = ST_COPY;
						end else begin
							state_d = ST_LEFT;
						end
					end
					CMD_RIGHT: state_d = ST_RIGHT;
					CMD_LEFT:  state_d = ST_LEFT;
					CMD_CLEAR: state_d = ST_FILL;
					default:   state_d = ST_DONE;
				endcase
			end
			ST_COPY: begin
				if (cnt_q == '0) begin
					case (job_q)
						JOB_SCROLL: state_d = ST_FILL;
						JOB_SHIFT:  state_d = ST_PUT;
						default:    state_d = ST_LEFT;
					endcase
				end
			end
			ST_SCAN_RD: state_d = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (job_q == JOB_ROWSCAN) begin
					state_d = (!rd_full || cur_col_q == LAST_COL) ? ST_DONE : ST_SCAN_RD;
				end else if (!rd_full || a_q == LAST_CELL) begin
					state_d = (a_q == pos) ? ST_PUT : ST_COPY;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_RIGHT: state_d = ST_DONE;
			ST_LEFT: begin
				if (!at_prompt && cur_col_q == '0 && cur_row_q != '0) begin
					state_d = ST_SCAN_RD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_PUT:     state_d = (cur_col_q == LAST_COL) ? ST_NEWLINE : ST_DONE;
			ST_NEWLINE: state_d = (cur_row_q == LAST_ROW) ? ST_COPY : ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos;
		ram_wdata = BLANK_CELL;
		ram_raddr = pos;
		case (state_q)
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = a_q;
				ram_wdata = (job_q == JOB_INIT) ? '0 : BLANK_CELL;
			end
			ST_EXEC: begin
				if (cmd_q == CMD_WRITE && int'(row_q) < ROWS && int'(col_q) < COLUMNS) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(row_q) * ROW_SPAN + AW'(col_q);
					ram_wdata = {color_q, ch_q};
				end else if (cmd_q == CMD_BKSP && !at_prompt && cur_col_q == LAST_COL) begin
					ram_we = 1'b1;
				end
			end
			ST_COPY: begin
				ram_raddr = a_q;
				ram_we    = pend_s1;
				ram_waddr = wdst_s1;
				ram_wdata = ram_rdata;
			end
			ST_SCAN_RD: ram_raddr = a_q;
			ST_PUT: begin
				ram_we    = 1'b1;
				ram_wdata = {(cmd_q == CMD_INSERT) ? INSERT_COLOR : color_q, ch_q};
			end
			default: ;
		endcase
	end

	// datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_FILL;
			job_q     <= JOB_INIT;
			a_q       <= '0;
			b_q       <= '0;
			cnt_q     <= '0;
			up_q      <= 1'b1;
			pend_s1   <= 1'b0;
			cur_row_q <= '0;
			cur_col_q <= '0;
			lim_row_q <= '0;
			lim_col_q <= '0;
			ok_q      <= 1'b1;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == ST_COPY) && (cnt_q != '0);

			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_LIMIT_ROW: lim_row_q <= cfg_data[ROW_W-1:0];
					default:       lim_col_q <= cfg_data;
				endcase
			end

			// raise the result word when done, drop it once taken
			if (state_q == ST_DONE && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end

			case (state_q)
				ST_FILL: begin
					a_q <= a_q + AW'(1);
				end
				ST_EXEC: begin
					// backspace reports only whether the edit took effect
					ok_q <= (cmd_q != CMD_BKSP) || (!at_prompt && cur_col_q != '0);
					case (cmd_q)
						CMD_INSERT: begin
							a_q   <= pos;
							job_q <= JOB_SHIFT;
						end
						CMD_BKSP: begin
							// shift the rest of the row left by one
							a_q   <= pos;
							b_q   <= pos - AW'(1);
							cnt_q <= AW'(COLUMNS) - AW'(cur_col_q);
							up_q  <= 1'b1;
							job_q <= JOB_BKSP;
						end
						CMD_CLEAR: begin
							a_q       <= '0;
							job_q     <= JOB_CLEAR;
							cur_row_q <= '0;
							cur_col_q <= '0;
						end
						CMD_SETCUR: begin
							cur_row_q <= (int'(row_q) < ROWS) ? row_q : LAST_ROW;
							cur_col_q <= (int'(col_q) < COLUMNS) ? col_q : LAST_COL;
						end
						default: ;
					endcase
				end
				ST_COPY: begin
					if (cnt_q != '0) begin
						wdst_s1 <= b_q;
						cnt_q   <= cnt_q - AW'(1);
						a_q     <= up_q ? a_q + AW'(1) : a_q - AW'(1);
						b_q     <= up_q ? b_q + AW'(1) : b_q - AW'(1);
					end else if (job_q == JOB_SCROLL) begin
						a_q <= AW'(CELLS - COLUMNS);
					end
				end
				ST_SCAN_CHK: begin
					if (job_q == JOB_ROWSCAN) begin
						if (rd_full && cur_col_q != LAST_COL) begin
							cur_col_q <= cur_col_q + COL_W'(1);
							a_q       <= a_q + AW'(1);
						end
					end else if (!rd_full || a_q == LAST_CELL) begin
						// run ends here: move cells pos..a_q-1 up by one, last first
						a_q   <= a_q - AW'(1);
						b_q   <= a_q;
						cnt_q <= a_q - pos;
						up_q  <= 1'b0;
					end else begin
						a_q <= a_q + AW'(1);
					end
				end
				ST_RIGHT: begin
					if (!rd_full) begin
						ok_q <= 1'b0;
					end else if (cur_col_q == LAST_COL) begin
						if (cur_row_q == LAST_ROW) begin
							ok_q <= 1'b0;
						end else begin
							cur_row_q <= cur_row_q + ROW_W'(1);
							cur_col_q <= '0;
						end
					end else begin
						cur_col_q <= cur_col_q + COL_W'(1);
					end
				end
				ST_LEFT: begin
					if (at_prompt) begin
						if (cmd_q == CMD_LEFT) ok_q <= 1'b0;
					end else if (cur_col_q != '0) begin
						cur_col_q <= cur_col_q - COL_W'(1);
					end else if (cur_row_q == '0) begin
						if (cmd_q == CMD_LEFT) ok_q <= 1'b0;
					end else begin
						// look for the first empty cell of the row above
						cur_row_q <= cur_row_q - ROW_W'(1);
						a_q       <= pos - ROW_SPAN;
						job_q     <= JOB_ROWSCAN;
					end
				end
				ST_PUT: begin
					if (cur_col_q != LAST_COL) begin
						cur_col_q <= cur_col_q + COL_W'(1);
					end
				end
				ST_NEWLINE: begin
					cur_col_q <= '0;
					if (cur_row_q == LAST_ROW) begin
						// scroll: rows 1.. move up one row, then blank the last row
						a_q   <= ROW_SPAN;
						b_q   <= '0;
						cnt_q <= AW'(CELLS - COLUMNS);
						up_q  <= 1'b1;
						job_q <= JOB_SCROLL;
					end else begin
						cur_row_q <= cur_row_q + ROW_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// command word and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cmd_q   <= cmd_t'(command);
			row_q   <= row;
			col_q   <= col;
			ch_q    <= char_code;
			color_q <= {bg, fg};
		end
		if (state_q == ST_DONE && out_free) begin
			cursor_row <= cur_row_q;
			cursor_col <= cur_col_q;
			success    <= ok_q;
		end
	end

endmodule
`default_nettype wire
